@@ sv/bbc_pkg.sv @@
package bbc_pkg;

  localparam logic [1:0] FUNC_GET     = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_PIN     = 2'd2;
  localparam logic [1:0] FUNC_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_COUNT    = 2'd2;
  localparam logic [1:0] ST_DEV_ZERO = 2'd3;

  localparam logic [7:0] COUNT_MAX = 8'hff;

  // one table entry as stored in the memory
  typedef struct packed {
    logic        in_use;
    logic [7:0]  tag_device;
    logic [31:0] tag_block;
    logic [7:0]  ref_count;
    logic [31:0] last_use;
    logic        loaded;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ sv/bbc_ram.sv @@
module bbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/block_buffer_cache_lru.sv @@
// Channel  Dir  Handshake            Payload
// in       in   in_valid/in_ready    func device block_number entry_index current_tick
// out      out  out_valid/out_ready  entry hit needs_read status
//
// After reset a clearing pass writes every entry to zero, with in_ready
// low. A get reads the table through the single read port, one entry a
// cycle, then passes through the write step and posts the result; a get for
// device zero posts ST_DEV_ZERO without a scan. Release, pin and unpin read
// the addressed entry, then pass through the write step and post the result.
// One item is in work at a time; in_ready stays low until the result is taken.
module block_buffer_cache_lru #(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  device,
  input  logic [31:0] block_number,
  input  logic [4:0]  entry_index,
  input  logic [31:0] current_tick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  entry,
  output logic        hit,
  output logic        needs_read,
  output logic [1:0]  status
);

  import bbc_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_RMW   = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]    state;
  logic [CW-1:0] addr;       // read address counter
  logic          rd_vld;     // read data valid this cycle
  logic [AW-1:0] rd_idx;     // index of the data on rdata

  logic [1:0]  op_func;
  logic [7:0]  op_dev;
  logic [31:0] op_blk;
  logic [4:0]  op_idx;
  logic [31:0] op_tick;

  logic          found_hit;
  logic [AW-1:0] hit_idx;
  entry_t        hit_ent;
  logic          found_free;
  logic [AW-1:0] free_idx;
  logic          found_old;
  logic [AW-1:0] old_idx;
  logic [31:0]   old_stamp;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [ENTRY_W-1:0] rdata_raw;
  entry_t        rdata;
  logic [AW-1:0] raddr;

  // result and write-back computed from the finished scan or read
  logic [4:0]    res_entry;
  logic          res_hit;
  logic          res_nr;
  logic [1:0]    res_status;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  assign rdata = entry_t'(rdata_raw);
  assign raddr = addr[AW-1:0];

  bbc_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  logic idx_ok;
  assign idx_ok = ({27'd0, op_idx} < 32'(ENTRIES));

  assign in_ready = (state == S_IDLE) && !out_valid;

  // decide the result and the entry to write back
  always_comb begin
    res_entry  = '0;
    res_hit    = 1'b0;
    res_nr     = 1'b0;
    res_status = ST_OK;
    wr_en      = 1'b0;
    wr_addr    = hit_idx;
    wr_data    = hit_ent;
    if (op_func == FUNC_GET) begin
      if (found_hit) begin
        res_entry = 5'(hit_idx);
        res_hit   = 1'b1;
        if (hit_ent.ref_count == COUNT_MAX) begin
          res_status = ST_COUNT;
        end else begin
          res_nr            = !hit_ent.loaded;
          wr_en             = 1'b1;
          wr_data.ref_count = hit_ent.ref_count + 8'd1;
          wr_data.last_use  = op_tick;
          wr_data.loaded    = 1'b1;
        end
      end else if (found_free || found_old) begin
        res_entry = found_free ? 5'(free_idx) : 5'(old_idx);
        res_nr    = 1'b1;
        wr_en     = 1'b1;
        wr_addr   = found_free ? free_idx : old_idx;
        wr_data   = '{in_use: 1'b1, tag_device: op_dev, tag_block: op_blk,
                      ref_count: 8'd1, last_use: op_tick, loaded: 1'b1};
      end else begin
        res_status = ST_NO_FREE;
      end
    end else begin
      res_entry = op_idx;
      wr_addr   = AW'(op_idx);
      if (idx_ok) begin
        if (op_func == FUNC_PIN) begin
          if (hit_ent.ref_count == COUNT_MAX) begin
            res_status = ST_COUNT;
          end else begin
            wr_en             = 1'b1;
            wr_data.ref_count = hit_ent.ref_count + 8'd1;
          end
        end else if (hit_ent.ref_count == 8'd0) begin
          res_status = ST_COUNT;
        end else begin
          wr_en             = 1'b1;
          wr_data.ref_count = hit_ent.ref_count - 8'd1;
          if (op_func == FUNC_RELEASE && hit_ent.ref_count == 8'd1) begin
            wr_data.last_use = op_tick;
          end
        end
      end
    end
  end

  // memory write port: clearing pass, then write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      we <= 1'b0;
    end else if (state == S_CLEAR) begin
      we    <= 1'b1;
      waddr <= addr[AW-1:0];
      wdata <= '0;
    end else if (state == S_WRITE) begin
      we    <= wr_en;
      waddr <= wr_addr;
      wdata <= wr_data;
    end else begin
      we <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      addr      <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (addr == CW'(ENTRIES - 1)) begin
            addr  <= '0;
            state <= S_IDLE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op_func    <= func;
            op_dev     <= device;
            op_blk     <= block_number;
            op_idx     <= entry_index;
            op_tick    <= current_tick;
            found_hit  <= 1'b0;
            found_free <= 1'b0;
            found_old  <= 1'b0;
            rd_vld     <= 1'b0;
            if (func == FUNC_GET) begin
              if (device == 8'd0) begin
                entry <= '0; hit <= 1'b0; needs_read <= 1'b0;
                status <= ST_DEV_ZERO;
                state <= S_DONE;
              end else begin
                addr  <= '0;
                state <= S_SCAN;
              end
            end else begin
              addr  <= CW'(entry_index);
              state <= S_RMW;
            end
          end
        end
        S_SCAN: begin
          // issue reads 0..ENTRIES-1, consume each in the next cycle
          if (addr < CW'(ENTRIES)) begin
            rd_vld <= 1'b1;
            rd_idx <= addr[AW-1:0];
            addr   <= addr + 1'b1;
          end else begin
            rd_vld <= 1'b0;
          end
          if (rd_vld) begin
            if (!found_hit && rdata.in_use && rdata.tag_device == op_dev &&
                rdata.tag_block == op_blk) begin
              found_hit <= 1'b1;
              hit_idx   <= rd_idx;
              hit_ent   <= rdata;
            end
            if (!found_free && !rdata.in_use && rdata.ref_count == 8'd0) begin
              found_free <= 1'b1;
              free_idx   <= rd_idx;
            end
            if (rdata.in_use && rdata.ref_count == 8'd0 &&
                (!found_old || rdata.last_use < old_stamp)) begin
              found_old <= 1'b1;
              old_idx   <= rd_idx;
              old_stamp <= rdata.last_use;
            end
          end
          if (!rd_vld && addr == CW'(ENTRIES)) begin
            state <= S_WRITE;
          end
        end
        S_RMW: begin
          // rd_vld low: read issued; rd_vld high: data ready and taken into hit_ent
          if (!rd_vld) begin
            rd_vld <= 1'b1;
          end else begin
            rd_vld <= 1'b0;
            hit_ent <= rdata;
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          entry      <= res_entry;
          hit        <= res_hit;
          needs_read <= res_nr;
          status     <= res_status;
          state      <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // no new transfer while a result is pending
  a_no_accept_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("accept while result pending");
  // no write in idle when the state before was idle too
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && $past(state) == S_IDLE) |-> !we)
    else $error("write in idle");
  // a hit is only reported with status ok or count error
  a_hit_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> (status == ST_OK || status == ST_COUNT))
    else $error("bad hit status");
`endif

endmodule
